/* rtl/esbm_pkg.sv */
// Shared types and constants of the event slice block matching flow block.
package esbm_pkg;

   localparam int NUM_SLICES = 3;

   // item kinds carried in req_tuser
   localparam logic [1:0] FUNC_ACC  = 2'd0;
   localparam logic [1:0] FUNC_ROT  = 2'd1;
   localparam logic [1:0] FUNC_FLOW = 2'd2;

   localparam logic [14:0] SAD_MAX = 15'h7fff;

   typedef struct packed {
      logic load;      // capture the accepted word
      logic acc_wr;    // write back incremented count
      logic q_start;   // start the offset search
      logic res_load;  // move result into the output register
   } esbm_cmd_type;

   typedef struct packed {
      logic clr_busy;  // clearing sweep running
      logic q_done;    // last offset compared
      logic win_ok;    // query window lies inside the image
      logic out_busy;  // output register still holds an untaken word
   } esbm_stat_type;

endpackage

/* rtl/esbm_ram.sv */
// Single-port-write, single-port-read count memory with registered read data.
module esbm_ram #(
   parameter int DEPTH = 43200,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/esbm_datapath.sv */
// Slice memories, clearing sweep, accumulate path and block SAD search datapath.
module esbm_datapath import esbm_pkg::*; #(
   parameter int IMG_WIDTH  = 240,
   parameter int IMG_HEIGHT = 180
) (
   input  logic          clock,
   input  logic          reset,
   input  esbm_cmd_type  cmd,
   output esbm_stat_type stat,
   input  logic [1:0]    item_func,
   input  logic [7:0]    item_x,
   input  logic [7:0]    item_y,
   input  logic          item_pol,
   input  logic [2:0]    cfg_sd,
   input  logic [3:0]    cfg_bs,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [3:0]    flow_dx,
   output logic [3:0]    flow_dy,
   output logic [14:0]   sad_value,
   output logic          valid_res
);

   localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] pix_addr(input logic signed [11:0] row,
                                              input logic signed [11:0] col);
      logic [AW+11:0] prod;
      prod = (AW+12)'(unsigned'(row)) * (AW+12)'(IMG_WIDTH);
      return AW'(prod) + AW'(unsigned'(col));
   endfunction

   // item capture
   logic [1:0]  func_ff;
   logic [7:0]  x_ff, y_ff;
   logic [AW-1:0] acc_addr_ff;
   logic        acc_ok_ff;
   logic [1:0]  cur_ff, cur_in;
   logic [1:0]  prev, prev2;

   // clearing sweep
   logic          clr_busy_ff, clr_all_ff;
   logic [AW-1:0] clr_addr_ff;

   // memories
   logic [NUM_SLICES-1:0] we;
   logic [AW-1:0]         waddr;
   logic [7:0]            wdata;
   logic [AW-1:0]         raddr [NUM_SLICES];
   logic [7:0]            rdata [NUM_SLICES];

   // search
   logic signed [3:0] sd_s, r_s;
   logic signed [3:0] dx_ff, dy_ff, i_ff, j_ff;
   logic              issue_ff;
   logic              p1_valid_ff, p1_last_ff, p1_final_ff;
   logic signed [3:0] p1_dx_ff, p1_dy_ff;
   logic [AW-1:0]     a_addr_ff, b_addr_ff;
   logic              p2_valid_ff, p2_last_ff, p2_final_ff;
   logic signed [3:0] p2_dx_ff, p2_dy_ff;
   logic [15:0]       sum_ff;
   logic [14:0]       best_ff;
   logic signed [3:0] bdx_ff, bdy_ff;
   logic              found_ff, done_ff;

   logic signed [11:0] xs, ys, lo_x, hi_x, lo_y, hi_y;
   logic [7:0]  rd_a, rd_b, diff;
   logic [16:0] s_full;
   logic [14:0] s_sat;
   logic        last_pix, final_off;

   assign r_s  = (cfg_bs == 4'd0) ? 4'sd0 : signed'({1'b0, 3'((cfg_bs - 4'd1) >> 1)});
   assign sd_s = signed'({1'b0, cfg_sd});

   assign xs   = signed'({4'b0, x_ff});
   assign ys   = signed'({4'b0, y_ff});
   assign lo_x = xs - 12'(r_s) - 12'(sd_s);
   assign hi_x = xs + 12'(r_s) + 12'(sd_s);
   assign lo_y = ys - 12'(r_s) - 12'(sd_s);
   assign hi_y = ys + 12'(r_s) + 12'(sd_s);

   assign prev  = (cur_ff == 2'd0) ? 2'd2 : cur_ff - 2'd1;
   assign prev2 = (cur_ff == 2'd2) ? 2'd0 : cur_ff + 2'd1;

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load && item_func == FUNC_ROT) begin
         cur_in = (cur_ff == 2'd2) ? 2'd0 : cur_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= 2'd0;
         clr_busy_ff <= 1'b1;
         clr_all_ff  <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         if (cmd.load && item_func == FUNC_ROT) begin
            clr_busy_ff <= 1'b1;
            clr_all_ff  <= 1'b0;
            clr_addr_ff <= '0;
         end else if (clr_busy_ff) begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= item_func;
         x_ff        <= item_x;
         y_ff        <= item_y;
         acc_ok_ff   <= item_pol && (32'(item_x) < IMG_WIDTH) && (32'(item_y) < IMG_HEIGHT);
         acc_addr_ff <= pix_addr(signed'({4'b0, item_y}), signed'({4'b0, item_x}));
      end
   end

   // memory ports
   assign waddr = clr_busy_ff ? clr_addr_ff : acc_addr_ff;
   assign wdata = clr_busy_ff ? 8'd0 : rdata[cur_ff] + 8'd1;

   for (genvar k = 0; k < NUM_SLICES; k++) begin : g_slice
      assign we[k] = clr_busy_ff ? (clr_all_ff || cur_ff == 2'(k))
                                 : (cmd.acc_wr && acc_ok_ff && cur_ff == 2'(k));
      assign raddr[k] = (cur_ff == 2'(k)) ? acc_addr_ff :
                        (prev == 2'(k))   ? a_addr_ff : b_addr_ff;
      esbm_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
         .clock (clock),
         .we    (we[k]),
         .waddr (waddr),
         .wdata (wdata),
         .raddr (raddr[k]),
         .rdata (rdata[k])
      );
   end

   // issue stage: walk dx, dy, then the block pixels
   assign last_pix  = (i_ff == r_s) && (j_ff == r_s);
   assign final_off = last_pix && (dx_ff == sd_s) && (dy_ff == sd_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         p1_valid_ff <= issue_ff;
         p2_valid_ff <= p1_valid_ff;
         done_ff     <= p2_valid_ff && p2_final_ff;
         if (cmd.q_start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && final_off) begin
            issue_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         dx_ff <= -sd_s;
         dy_ff <= -sd_s;
         i_ff  <= -r_s;
         j_ff  <= -r_s;
      end else if (issue_ff) begin
         if (j_ff != r_s) begin
            j_ff <= j_ff + 4'sd1;
         end else begin
            j_ff <= -r_s;
            if (i_ff != r_s) begin
               i_ff <= i_ff + 4'sd1;
            end else begin
               i_ff <= -r_s;
               if (dy_ff != sd_s) begin
                  dy_ff <= dy_ff + 4'sd1;
               end else begin
                  dy_ff <= -sd_s;
                  dx_ff <= dx_ff + 4'sd1;
               end
            end
         end
      end
      p1_last_ff  <= last_pix;
      p1_final_ff <= final_off;
      p1_dx_ff    <= dx_ff;
      p1_dy_ff    <= dy_ff;
      a_addr_ff   <= pix_addr(ys + 12'(j_ff), xs + 12'(i_ff));
      b_addr_ff   <= pix_addr(ys + 12'(dy_ff) + 12'(j_ff), xs + 12'(dx_ff) + 12'(i_ff));
      p2_last_ff  <= p1_last_ff;
      p2_final_ff <= p1_final_ff;
      p2_dx_ff    <= p1_dx_ff;
      p2_dy_ff    <= p1_dy_ff;
   end

   // accumulate stage, compare at the end of each offset
   assign rd_a   = rdata[prev];
   assign rd_b   = rdata[prev2];
   assign diff   = (rd_a >= rd_b) ? rd_a - rd_b : rd_b - rd_a;
   assign s_full = 17'(sum_ff) + 17'(diff);
   assign s_sat  = (s_full > 17'(SAD_MAX)) ? SAD_MAX : 15'(s_full);

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         sum_ff   <= '0;
         found_ff <= 1'b0;
         best_ff  <= '0;
         bdx_ff   <= '0;
         bdy_ff   <= '0;
      end else if (p2_valid_ff) begin
         if (p2_last_ff) begin
            sum_ff <= '0;
            if (!found_ff || s_sat < best_ff) begin
               found_ff <= 1'b1;
               best_ff  <= s_sat;
               bdx_ff   <= -p2_dx_ff;
               bdy_ff   <= -p2_dy_ff;
            end
         end else begin
            sum_ff <= 16'(s_full);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         flow_dx   <= stat.win_ok ? bdx_ff : 4'd0;
         flow_dy   <= stat.win_ok ? bdy_ff : 4'd0;
         sad_value <= stat.win_ok ? best_ff : 15'd0;
         valid_res <= stat.win_ok;
      end
   end

   assign stat.clr_busy = clr_busy_ff;
   assign stat.q_done   = done_ff;
   assign stat.win_ok   = (lo_x >= 12'sd0) && (hi_x < 12'(IMG_WIDTH)) &&
                          (lo_y >= 12'sd0) && (hi_y < 12'(IMG_HEIGHT));
   assign stat.out_busy = rsp_valid && !rsp_ready;

   logic unused_func;
   assign unused_func = ^func_ff;

endmodule

/* rtl/esbm_ctrl.sv */
// Controller state machine sequencing clears, accumulates and flow queries.
module esbm_ctrl import esbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_func,
   output logic          req_ready,
   input  esbm_stat_type stat,
   output esbm_cmd_type  cmd
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_ARD  = 3'd2;
   localparam logic [2:0] S_AWR  = 3'd3;
   localparam logic [2:0] S_QCHK = 3'd4;
   localparam logic [2:0] S_QRUN = 3'd5;
   localparam logic [2:0] S_QOUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = take;
      case (state_ff)
         S_CLR: begin
            if (!stat.clr_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (take) begin
               case (req_func)
                  FUNC_ACC:  state_in = S_ARD;
                  FUNC_ROT:  state_in = S_CLR;
                  FUNC_FLOW: state_in = S_QCHK;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ARD: state_in = S_AWR;
         S_AWR: begin
            cmd.acc_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_QCHK: begin
            if (stat.win_ok) begin
               cmd.q_start = 1'b1;
               state_in    = S_QRUN;
            end else begin
               state_in = S_QOUT;
            end
         end
         S_QRUN: begin
            if (stat.q_done) state_in = S_QOUT;
         end
         S_QOUT: begin
            if (!stat.out_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/event_slice_block_match_flow.sv */
// Top level: stream ports, register port, controller and datapath.
// Keeps three rotating 8-bit count slices of IMG_WIDTH x IMG_HEIGHT in three
// memories. After reset the block clears all slices, one cell per cycle, and
// req_tready rises once the clearing sweep is done. An accumulate word is
// accepted, read and written back. A rotate word clears the new slice before
// the next word is taken. A flow query reads one block pixel pair from the two
// older slice memories per cycle, so the memory read port sets the rate; an
// out-of-bounds query skips the search. A finished result sits in an output
// register, so accumulate and rotate words continue while it waits.
module event_slice_block_match_flow import esbm_pkg::*; #(
   parameter int IMG_WIDTH  = 240,
   parameter int IMG_HEIGHT = 180
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // x[7:0], y[15:8], polarity[16], zero
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // flow_dx[3:0], flow_dy[7:4], sad_value[22:8], zero
   output logic [0:0]  rsp_tuser,  // valid_res[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_SD = 1'b0;
   localparam logic REG_BS = 1'b1;

   logic [2:0]    sd_ff;
   logic [3:0]    bs_ff;
   esbm_cmd_type  cmd;
   esbm_stat_type stat;
   logic [3:0]    flow_dx, flow_dy;
   logic [14:0]   sad_value;
   logic          valid_res;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff <= 3'd3;
         bs_ff <= 4'd5;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_SD:  sd_ff <= csr_pwdata[2:0];
            REG_BS:  bs_ff <= csr_pwdata[3:0];
            default: sd_ff <= sd_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SD:  csr_prdata = {29'd0, sd_ff};
         REG_BS:  csr_prdata = {28'd0, bs_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   esbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   esbm_datapath #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .item_func (req_tuser),
      .item_x    (req_tdata[7:0]),
      .item_y    (req_tdata[15:8]),
      .item_pol  (req_tdata[16]),
      .cfg_sd    (sd_ff),
      .cfg_bs    (bs_ff),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .flow_dx   (flow_dx),
      .flow_dy   (flow_dy),
      .sad_value (sad_value),
      .valid_res (valid_res)
   );

   assign rsp_tdata = {1'b0, sad_value, flow_dy, flow_dx};
   assign rsp_tuser = valid_res;

   logic unused_in;
   assign unused_in = ^{req_tdata[23:17], csr_paddr[1:0], csr_pwdata[31:4]};

endmodule

/* rtl/esbm_checker.sv */
// Port-level checks of the flow block, bound to the top level.
module esbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // invalid query result carries all zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == 1'b0 |-> rsp_tdata == 24'd0)
      else $error("invalid result with nonzero fields");

   // motion never reaches the most negative code
   a_flow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] != 4'b1000 && rsp_tdata[7:4] != 4'b1000)
      else $error("flow component out of range");

   // clearing sweep holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input taken before clearing sweep");

endmodule

bind event_slice_block_match_flow esbm_checker u_esbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/tb.sv */
// Self-checking testbench for the event slice block matching flow block.
module tb import esbm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 240;
   localparam int H = 180;
   localparam int CELLS = W * H;
   localparam logic [2:0] REG_SEARCH_DIST = 3'd0;
   localparam logic [2:0] REG_BLOCK_SIZE  = 3'd4;
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int SLICE_CLEAR_CYCLES = CELLS + 800;

   typedef struct packed {
      logic [3:0]  dx;
      logic [3:0]  dy;
      logic [14:0] sad;
      logic        ok;
   } flow_type;

   typedef struct {
      logic [1:0] func;
      int         x;
      int         y;
      bit         pol;
      bit         typed;
      flow_type   want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   event_slice_block_match_flow i_dut (.*);

   always #2 clock = ~clock;

   // predictor state
   byte unsigned counts [3][CELLS];
   int           cur_slice;
   int           search_dist;
   int           block_sz;

   flow_type flow_q[$];
   int    errors, n_acc, n_rot, n_flow, n_flow_ok, n_words;
   bit    quiet;
   int    rsp_stall;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   function automatic flow_type predict_flow(int x, int y);
      int       r, sd, p1, p2, s, a, b, best_dx, best_dy, best;
      flow_type res;
      bit       found;
      res = '0;
      sd = search_dist;
      r = (block_sz == 0) ? 0 : (block_sz - 1) / 2;
      if (x - r - sd < 0 || x + r + sd >= W || y - r - sd < 0 || y + r + sd >= H)
         return res;
      p1 = (cur_slice + 2) % 3;
      p2 = (cur_slice + 1) % 3;
      found = 0;
      best = 0; best_dx = 0; best_dy = 0;
      for (int dx = -sd; dx <= sd; dx++) begin
         for (int dy = -sd; dy <= sd; dy++) begin
            s = 0;
            for (int i = -r; i <= r; i++) begin
               for (int j = -r; j <= r; j++) begin
                  a = counts[p1][(y + j) * W + x + i];
                  b = counts[p2][(y + dy + j) * W + x + dx + i];
                  s += (a > b) ? a - b : b - a;
               end
            end
            if (s > 32767) s = 32767;
            if (!found || s < best) begin
               found = 1;
               best = s;
               best_dx = -dx;
               best_dy = -dy;
            end
         end
      end
      res.dx = best_dx[3:0];
      res.dy = best_dy[3:0];
      res.sad = best[14:0];
      res.ok = 1'b1;
      return res;
   endfunction

   // applies an accepted word to the predictor; typed rows override the query result
   task automatic apply_word(logic [1:0] func, int x, int y, bit pol, bit typed,
                             flow_type want);
      case (func)
         FUNC_ACC: begin
            n_acc++;
            if (pol && x < W && y < H)
               counts[cur_slice][y * W + x] = counts[cur_slice][y * W + x] + 8'd1;
         end
         FUNC_ROT: begin
            n_rot++;
            cur_slice = (cur_slice + 1) % 3;
            for (int k = 0; k < CELLS; k++) counts[cur_slice][k] = 8'd0;
         end
         FUNC_FLOW: begin
            n_flow++;
            flow_q.push_back(typed ? want : predict_flow(x, y));
         end
         default: ;
      endcase
   endtask

   task automatic send(logic [1:0] func, int x, int y, bit pol, bit typed, flow_type want);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, pol, y[7:0], x[7:0]};
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
      n_words++;
      apply_word(func, x, y, pol, typed, want);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (flow_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, int value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == REG_SEARCH_DIST) search_dist = value & 7;
      else block_sz = value & 15;
   endtask

   // result checker
   always @(posedge clock) begin
      flow_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[22:8], rsp_tuser[0]};
         if (flow_q.size() == 0) begin
            report("unexpected word", got, 0);
         end else begin
            want = flow_q.pop_front();
            if (got.dx != want.dx) report("flow_dx", got.dx, want.dx);
            if (got.dy != want.dy) report("flow_dy", got.dy, want.dy);
            if (got.sad != want.sad) report("sad_value", got.sad, want.sad);
            if (got.ok != want.ok) report("valid_res", got.ok, want.ok);
            if (want.ok) n_flow_ok++;
         end
      end
   end

   // receiver back-pressure in short bursts
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_tready <= !reset;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic row_type mk(logic [1:0] func, int x, int y, bit pol, bit typed = 0,
                                  flow_type want = '0);
      row_type rw;
      rw.func = func; rw.x = x; rw.y = y; rw.pol = pol; rw.typed = typed; rw.want = want;
      return rw;
   endfunction

   initial begin
      row_type  rows[$];
      int       cfg_sd[6] = '{1, 0, 2, 7, 4, 2};
      int       cfg_bs[6] = '{3, 0, 5, 15, 11, 3};
      int       qpct, pick, x, y;
      flow_type none;
      none = '0;
      cur_slice = 0; search_dist = 3; block_sz = 5;
      for (int s = 0; s < 3; s++) for (int k = 0; k < CELLS; k++) counts[s][k] = 8'd0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset values, image edges, ignored words, rotations
      rows.push_back(mk(FUNC_FLOW, 120, 90, 0, 1, flow_type'{4'd3, 4'd3, 15'd0, 1'b1}));
      rows.push_back(mk(FUNC_FLOW, 0, 0, 1, 1, none));
      rows.push_back(mk(FUNC_FLOW, 255, 255, 1, 1, none));
      rows.push_back(mk(FUNC_ACC, 120, 90, 1));
      rows.push_back(mk(FUNC_ACC, 121, 90, 1));
      rows.push_back(mk(FUNC_ACC, 255, 255, 1));
      rows.push_back(mk(FUNC_ACC, 240, 179, 1));
      rows.push_back(mk(FUNC_ACC, 239, 180, 1));
      rows.push_back(mk(FUNC_ACC, 239, 179, 1));
      rows.push_back(mk(FUNC_ACC, 0, 0, 1));
      rows.push_back(mk(FUNC_ACC, 122, 91, 0));
      rows.push_back(mk(FUNC_NONE, 120, 90, 1));
      rows.push_back(mk(FUNC_ROT, 0, 0, 0));
      rows.push_back(mk(FUNC_ACC, 118, 92, 1));
      rows.push_back(mk(FUNC_ACC, 119, 92, 1));
      rows.push_back(mk(FUNC_ACC, 120, 90, 1));
      rows.push_back(mk(FUNC_ROT, 255, 255, 1));
      rows.push_back(mk(FUNC_FLOW, 120, 90, 1));
      rows.push_back(mk(FUNC_FLOW, 5, 5, 0));
      rows.push_back(mk(FUNC_FLOW, 4, 90, 0));
      rows.push_back(mk(FUNC_FLOW, 234, 174, 0));
      rows.push_back(mk(FUNC_FLOW, 235, 90, 0));
      foreach (rows[i])
         send(rows[i].func, rows[i].x, rows[i].y, rows[i].pol, rows[i].typed, rows[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         // a rotation keeps the block busy long after its last result
         repeat (SLICE_CLEAR_CYCLES) @(posedge clock);
         csr_write(REG_SEARCH_DIST, cfg_sd[ph]);
         csr_write(REG_BLOCK_SIZE, cfg_bs[ph]);
         quiet = (ph == 5);
         qpct = (cfg_sd[ph] >= 4) ? 1 : 12;
         for (int n = 0; n < 215; n++) begin
            if (n == 120) begin
               send(FUNC_ROT, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 1), 0, none);
            end else if (ph == 1 && n >= 10 && n < 40) begin
               // hot pixel: pushes one count past its wrap point
               for (int k = 0; k < 9; k++) send(FUNC_ACC, 121, 89, 1, 0, none);
            end else if (ph == 2 && n == 200) begin
               drain();
            end else begin
               pick = $urandom_range(0, 99);
               x = 120 + $signed($urandom_range(0, 24)) - 12;
               y = 90 + $signed($urandom_range(0, 24)) - 12;
               if (pick < qpct) begin
                  if ($urandom_range(0, 7) == 0) begin
                     x = $urandom_range(0, 255); y = $urandom_range(0, 255);
                  end
                  send(FUNC_FLOW, x, y, $urandom_range(0, 1), 0, none);
               end else if (pick < qpct + 6) begin
                  send(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 1), 0, none);
               end else begin
                  send(FUNC_ACC, x, y, $urandom_range(0, 7) != 0, 0, none);
               end
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      $display("Run: %0d words, %0d accumulates, %0d rotations, %0d flow queries",
               n_words, n_acc, n_rot, n_flow);
      $display("Valid flow results checked: %0d, errors: %0d", n_flow_ok, errors);
      if (errors == 0 && flow_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/esbm_pkg.sv
rtl/esbm_ram.sv
rtl/esbm_datapath.sv
rtl/esbm_ctrl.sv
rtl/event_slice_block_match_flow.sv
rtl/esbm_checker.sv
tb/tb.sv
